// ===== hw/rtl/vpc_pkg.sv =====
`default_nettype none
package vpc_pkg;

  localparam int unsigned POS_W = 5;
  localparam logic [POS_W-1:0] POS_MAX = 5'd31;
  localparam logic [POS_W-1:0] POS_SIG_FIRST = 5'd1;
  localparam logic [POS_W-1:0] POS_SIG_LAST = 5'd6;
  localparam logic [POS_W-1:0] POS_HDR_MIN = 5'd7;
  localparam logic [POS_W-1:0] POS_CHANNELS = 5'd11;
  localparam logic [POS_W-1:0] POS_RATE_FIRST = 5'd12;
  localparam logic [POS_W-1:0] POS_RATE_LAST = 5'd15;
  localparam logic [POS_W-1:0] POS_BLOCKSIZE = 5'd28;

  localparam logic [7:0] HDR_IDENT = 8'h01;
  localparam logic [7:0] HDR_COMMENT = 8'h03;
  localparam logic [7:0] HDR_SETUP = 8'h05;

  localparam int unsigned AUDIO_FLAG_BIT = 1;

  typedef enum logic [1:0] {
    KIND_IDENT   = 2'd0,
    KIND_COMMENT = 2'd1,
    KIND_SETUP   = 2'd2,
    KIND_AUDIO   = 2'd3
  } kind_e;

  // per-packet capture, already including the byte being processed
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [7:0]       first_byte;
    logic             sig_ok;
    logic [7:0]       channels;
    logic [31:0]      rate;
    logic [7:0]       block_byte;
  } cap_t;

  localparam cap_t CAP_RESET = cap_t'({POS_W'(0), 8'h00, 1'b1, 8'h00, 32'h0, 8'h00});

  typedef struct packed {
    logic [14:0] sample_count;
    logic        block_flag;
    logic [15:0] long_size;
    logic [15:0] short_size;
    logic [31:0] rate_hz;
    logic [7:0]  channel_count;
    kind_e       packet_kind;
    logic        accepted;
  } res_t;

  function automatic logic [7:0] sig_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd1: c = 8'h76;  // v
      3'd2: c = 8'h6F;  // o
      3'd3: c = 8'h72;  // r
      3'd4: c = 8'h62;  // b
      3'd5: c = 8'h69;  // i
      3'd6: c = 8'h73;  // s
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/vpc_capture.sv =====
`default_nettype none
module vpc_capture (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        last_i,
  input  wire logic [7:0]  byte_i,
  output vpc_pkg::cap_t    cap_o
);
  import vpc_pkg::*;

  cap_t cap_q, cap_d;
  logic in_sig, in_rate;

  always_comb begin
    in_sig  = (cap_q.pos >= POS_SIG_FIRST) && (cap_q.pos <= POS_SIG_LAST);
    in_rate = (cap_q.pos >= POS_RATE_FIRST) && (cap_q.pos <= POS_RATE_LAST);

    cap_o = cap_q;
    if (cap_q.pos == '0) begin
      cap_o.first_byte = byte_i;
    end
    if (in_sig && (byte_i != sig_char(cap_q.pos[2:0]))) begin
      cap_o.sig_ok = 1'b0;
    end
    if (cap_q.pos == POS_CHANNELS) begin
      cap_o.channels = byte_i;
    end
    if (in_rate) begin
      cap_o.rate = cap_q.rate | ({24'd0, byte_i} << {cap_q.pos[1:0], 3'b000});
    end
    if (cap_q.pos == POS_BLOCKSIZE) begin
      cap_o.block_byte = byte_i;
    end
  end

  always_comb begin
    cap_d = cap_q;
    if (en_i) begin
      if (last_i) begin
        cap_d = CAP_RESET;
      end else begin
        cap_d = cap_o;
        if (cap_q.pos != POS_MAX) begin
          cap_d.pos = cap_q.pos + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else begin
      cap_q <= cap_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/vpc_decide.sv =====
`default_nettype none
module vpc_decide (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     en_i,
  input  vpc_pkg::cap_t cap_i,
  output vpc_pkg::res_t res_o
);
  import vpc_pkg::*;

  logic        have_prev_q, have_prev_d;
  logic [7:0]  chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] short_q, short_d;
  logic [15:0] long_q, long_d;
  logic        flag_q, flag_d;

  logic        is_hdr;
  logic        cur_flag;
  logic [16:0] sum;

  always_comb begin
    have_prev_d = have_prev_q;
    chan_d      = chan_q;
    rate_d      = rate_q;
    short_d     = short_q;
    long_d      = long_q;
    flag_d      = flag_q;
    res_o       = '0;

    is_hdr   = (cap_i.pos >= POS_HDR_MIN) && cap_i.sig_ok;
    cur_flag = cap_i.first_byte[AUDIO_FLAG_BIT];
    sum      = {1'b0, (flag_q ? long_q : short_q)} + {1'b0, (cur_flag ? long_q : short_q)};

    if (is_hdr) begin
      case (cap_i.first_byte)
        HDR_IDENT: begin
          if (cap_i.pos >= POS_BLOCKSIZE) begin
            have_prev_d = 1'b1;
            chan_d      = cap_i.channels;
            rate_d      = cap_i.rate;
            short_d     = 16'd1 << cap_i.block_byte[3:0];
            long_d      = 16'd1 << cap_i.block_byte[7:4];
            flag_d      = 1'b0;
            res_o.accepted    = 1'b1;
            res_o.packet_kind = KIND_IDENT;
          end
        end
        HDR_COMMENT, HDR_SETUP: begin
          if (have_prev_q) begin
            flag_d = 1'b0;
            res_o.accepted    = 1'b1;
            res_o.packet_kind = (cap_i.first_byte == HDR_COMMENT) ? KIND_COMMENT : KIND_SETUP;
          end
        end
        default: begin
        end
      endcase
    end else if (have_prev_q) begin
      flag_d = cur_flag;
      res_o.accepted     = 1'b1;
      res_o.packet_kind  = KIND_AUDIO;
      res_o.block_flag   = cur_flag;
      res_o.sample_count = sum[16:2];
    end

    if (res_o.accepted) begin
      res_o.channel_count = chan_d;
      res_o.rate_hz       = rate_d;
      res_o.short_size    = short_d;
      res_o.long_size     = long_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      chan_q      <= '0;
      rate_q      <= '0;
      short_q     <= '0;
      long_q      <= '0;
      flag_q      <= 1'b0;
    end else if (en_i) begin
      have_prev_q <= have_prev_d;
      chan_q      <= chan_d;
      rate_q      <= rate_d;
      short_q     <= short_d;
      long_q      <= long_d;
      flag_q      <= flag_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/vorbis_packet_classifier.sv =====
// A result is registered in the output register when the final byte leaves the input register.
// Throughput: one byte per cycle; a final byte waits in the input register
// only while the previous result is still held by m_axis_tready low.
// Reset: rst_ni (async, active low) clears the pipeline valids, the per-packet
// capture and the kept stream parameters; no clearing pass is needed.
`default_nettype none
module vorbis_packet_classifier (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [87:0]      m_axis_tdata,   // channel_count, rate_hz, short_size,
                                           // long_size, block_flag, sample_count
  output logic [2:0]       m_axis_tuser    // accepted, packet_kind
);
  import vpc_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  logic out_valid_q;
  res_t out_q;

  logic out_free;
  logic proc_fire;
  logic in_fire;

  cap_t cap;
  res_t res;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign proc_fire     = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || proc_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  vpc_capture u_capture (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (proc_fire),
    .last_i (in_last_q),
    .byte_i (in_byte_q),
    .cap_o  (cap)
  );

  vpc_decide u_decide (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (proc_fire && in_last_q),
    .cap_i  (cap),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && in_last_q) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.sample_count, out_q.block_flag, out_q.long_size,
                          out_q.short_size, out_q.rate_hz, out_q.channel_count};
  assign m_axis_tuser  = {out_q.packet_kind, out_q.accepted};

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import vpc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned RANDOM_BYTES = 1080;
  localparam int unsigned CALM_TAIL = 150;
  localparam int unsigned PRESS_AT = 400;
  localparam int unsigned PRESS_LEN = 300;
  localparam logic [47:0] SIG_TEXT = "vorbis";
  localparam res_t NO_RES = '0;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         typed;
    res_t       want;
  } byte_req_t;

  // one packet: header bytes follow the signature unless hdr is 0;
  // brk 1..6 corrupts that signature byte
  typedef struct {
    logic [7:0]  head;
    int unsigned len;
    bit          hdr;
    int unsigned brk;
    logic [7:0]  ch;
    logic [31:0] rate;
    logic [7:0]  blk;
    bit          typed;
    res_t        want;
  } pkt_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
  logic        s_axis_tlast = 1'b0; // last_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;        // channel_count, rate_hz, short_size, long_size,
                                    // block_flag, sample_count
  logic [2:0]  m_axis_tuser;        // accepted, packet_kind

  vorbis_packet_classifier dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  byte_req_t   stim_q[$];
  res_t        pending_results[$];
  int          send_idx = 0;
  int          send_gap = 0;
  int          hold_left = 0;
  bit          pressed = 1'b0;
  int          errors = 0;
  int unsigned cycles = 0;

  // classifier model state
  bit          seen_prev;
  logic [7:0]  keep_ch;
  logic [31:0] keep_rate;
  logic [15:0] keep_short;
  logic [15:0] keep_long;
  logic        keep_flag;
  logic [4:0]  pos;
  logic [7:0]  head_byte;
  bit          sig_good;
  logic [7:0]  grab_ch;
  logic [31:0] grab_rate;
  logic [7:0]  grab_blk;

  bit          got_done;
  res_t        got_res;

  function automatic res_t make_result(kind_e k, logic [7:0] ch, logic [31:0] rate,
                                       logic [15:0] s, logic [15:0] l, logic f,
                                       logic [14:0] n);
    res_t r;
    r.accepted = 1'b1;
    r.packet_kind = k;
    r.channel_count = ch;
    r.rate_hz = rate;
    r.short_size = s;
    r.long_size = l;
    r.block_flag = f;
    r.sample_count = n;
    return r;
  endfunction

  function automatic bit quiet_tail();
    return send_idx + CALM_TAIL >= stim_q.size();
  endfunction

  task automatic clear_capture();
    pos = '0;
    head_byte = '0;
    sig_good = 1'b1;
    grab_ch = '0;
    grab_rate = '0;
    grab_blk = '0;
  endtask

  task automatic classify_byte(input logic [7:0] b, input logic last,
                               output bit done, output res_t r);
    int unsigned p;
    logic [31:0] sum;
    logic        fl;
    p = 32'(pos);
    r = NO_RES;
    done = 1'b0;
    if (p == 0) begin
      head_byte = b;
    end else if (p <= 6 && b != SIG_TEXT[8*(6-p) +: 8]) begin
      sig_good = 1'b0;
    end
    if (p == 11) grab_ch = b;
    if (p >= 12 && p <= 15) grab_rate[8*(p-12) +: 8] = b;
    if (p == 28) grab_blk = b;
    if (!last) begin
      if (pos < POS_MAX) pos = pos + 5'd1;
    end else begin
      done = 1'b1;
      if (p >= 7 && sig_good) begin
        if (head_byte == HDR_IDENT) begin
          if (p >= 28) begin
            keep_ch = grab_ch;
            keep_rate = grab_rate;
            keep_short = 16'd1 << grab_blk[3:0];
            keep_long = 16'd1 << grab_blk[7:4];
            keep_flag = 1'b0;
            seen_prev = 1'b1;
            r = make_result(KIND_IDENT, keep_ch, keep_rate, keep_short, keep_long, 1'b0, '0);
          end
        end else if (head_byte == HDR_COMMENT || head_byte == HDR_SETUP) begin
          if (seen_prev) begin
            keep_flag = 1'b0;
            r = make_result(head_byte == HDR_COMMENT ? KIND_COMMENT : KIND_SETUP,
                            keep_ch, keep_rate, keep_short, keep_long, 1'b0, '0);
          end
        end
      end else if (seen_prev) begin
        sum = 32'(keep_flag ? keep_long : keep_short);
        fl = head_byte[AUDIO_FLAG_BIT];
        sum = sum + 32'(fl ? keep_long : keep_short);
        keep_flag = fl;
        r = make_result(KIND_AUDIO, keep_ch, keep_rate, keep_short, keep_long, fl, sum[16:2]);
      end
      clear_capture();
    end
  endtask

  task automatic append_packet(input pkt_row_t row);
    byte_req_t q;
    for (int unsigned p = 0; p < row.len; p++) begin
      if (p == 0) q.data = row.head;
      else if (!row.hdr) q.data = 8'($urandom_range(0, 255));
      else if (p <= 6) q.data = SIG_TEXT[8*(6-p) +: 8]
                                ^ (row.brk == p ? 8'h01 << $urandom_range(0, 7) : 8'h00);
      else if (p == 11) q.data = row.ch;
      else if (p >= 12 && p <= 15) q.data = row.rate[8*(p-12) +: 8];
      else if (p == 28) q.data = row.blk;
      else q.data = 8'($urandom_range(0, 255));
      q.last = (p == row.len - 1);
      q.typed = q.last && row.typed;
      q.want = row.want;
      stim_q.push_back(q);
    end
  endtask

  task automatic build_stimulus();
    pkt_row_t directed_tbl[17];
    pkt_row_t row;
    int unsigned start;
    int unsigned r;
    directed_tbl = '{
      '{8'h02, 1, 1'b0, 0, 8'h00, 32'h0, 8'h00, 1'b1, NO_RES},
      '{HDR_COMMENT, 8, 1'b1, 0, 8'h00, 32'h0, 8'h00, 1'b1, NO_RES},
      '{HDR_SETUP, 12, 1'b1, 0, 8'h00, 32'h0, 8'h00, 1'b1, NO_RES},
      '{HDR_IDENT, 28, 1'b1, 0, 8'd2, 32'd48000, 8'hB8, 1'b1, NO_RES},
      '{HDR_IDENT, 29, 1'b1, 0, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 1'b1,
        make_result(KIND_IDENT, 8'hFF, 32'hFFFF_FFFF, 16'd32768, 16'd32768, 1'b0, 15'd0)},
      '{8'hFF, 1, 1'b0, 0, 8'h00, 32'h0, 8'h00, 1'b1,
        make_result(KIND_AUDIO, 8'hFF, 32'hFFFF_FFFF, 16'd32768, 16'd32768, 1'b1, 15'd16384)},
      '{HDR_IDENT, 29, 1'b1, 0, 8'h00, 32'h0, 8'h00, 1'b1,
        make_result(KIND_IDENT, 8'h00, 32'h0, 16'd1, 16'd1, 1'b0, 15'd0)},
      '{8'h00, 2, 1'b0, 0, 8'h00, 32'h0, 8'h00, 1'b0, NO_RES},
      '{HDR_IDENT, 40, 1'b1, 0, 8'd2, 32'd44100, 8'hB8, 1'b0, NO_RES},
      '{HDR_COMMENT, 8, 1'b1, 0, 8'h00, 32'h0, 8'h00, 1'b0, NO_RES},
      '{HDR_SETUP, 20, 1'b1, 0, 8'h00, 32'h0, 8'h00, 1'b0, NO_RES},
      '{8'h07, 10, 1'b1, 0, 8'h00, 32'h0, 8'h00, 1'b1, NO_RES},
      '{HDR_IDENT, 29, 1'b1, 3, 8'd6, 32'd96000, 8'hA7, 1'b0, NO_RES},
      '{HDR_COMMENT, 7, 1'b1, 0, 8'h00, 32'h0, 8'h00, 1'b0, NO_RES},
      '{8'h02, 3, 1'b0, 0, 8'h00, 32'h0, 8'h00, 1'b0, NO_RES},
      '{8'hFD, 35, 1'b0, 0, 8'h00, 32'h0, 8'h00, 1'b0, NO_RES},
      '{HDR_SETUP, 9, 1'b1, 6, 8'h00, 32'h0, 8'h00, 1'b0, NO_RES}
    };
    foreach (directed_tbl[i]) append_packet(directed_tbl[i]);

    start = stim_q.size();
    while (stim_q.size() < start + RANDOM_BYTES) begin
      r = $urandom_range(0, 99);
      row = '{8'h00, 1, 1'b0, 0, 8'h00, 32'h0, 8'h00, 1'b0, NO_RES};
      row.ch = 8'($urandom_range(0, 255));
      row.rate = $urandom;
      row.blk = 8'($urandom_range(0, 255));
      if (r < 30) begin
        row.head = HDR_IDENT;
        row.hdr = 1'b1;
        row.len = ($urandom_range(0, 9) != 0) ? $urandom_range(29, 40) : $urandom_range(8, 28);
      end else if (r < 50) begin
        row.head = $urandom_range(0, 1) ? HDR_COMMENT : HDR_SETUP;
        row.hdr = 1'b1;
        row.len = $urandom_range(8, 24);
        if ($urandom_range(0, 7) == 0) row.brk = $urandom_range(1, 6);
      end else if (r < 85) begin
        row.head = 8'($urandom_range(0, 255));
        row.len = $urandom_range(1, 12);
      end else begin
        row.head = 8'($urandom_range(0, 255));
        row.hdr = 1'b1;
        row.len = $urandom_range(1, 16);
        row.brk = $urandom_range(0, 6);
      end
      append_packet(row);
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0h, expected %0h", what, got, want);
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (pending_results.size() == 0) begin
      report("unexpected result", 32'(got.packet_kind), 32'd0);
    end else begin
      want = pending_results.pop_front();
      if (got.accepted !== want.accepted)
        report("accepted", 32'(got.accepted), 32'(want.accepted));
      if (got.packet_kind !== want.packet_kind)
        report("packet_kind", 32'(got.packet_kind), 32'(want.packet_kind));
      if (got.channel_count !== want.channel_count)
        report("channel_count", 32'(got.channel_count), 32'(want.channel_count));
      if (got.rate_hz !== want.rate_hz) report("rate_hz", got.rate_hz, want.rate_hz);
      if (got.short_size !== want.short_size)
        report("short_size", 32'(got.short_size), 32'(want.short_size));
      if (got.long_size !== want.long_size)
        report("long_size", 32'(got.long_size), 32'(want.long_size));
      if (got.block_flag !== want.block_flag)
        report("block_flag", 32'(got.block_flag), 32'(want.block_flag));
      if (got.sample_count !== want.sample_count)
        report("sample_count", 32'(got.sample_count), 32'(want.sample_count));
    end
  endtask

  // byte sender
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        classify_byte(stim_q[send_idx].data, stim_q[send_idx].last, got_done, got_res);
        if (got_done) pending_results.push_back(stim_q[send_idx].typed ?
                                                stim_q[send_idx].want : got_res);
        send_idx++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (send_idx < stim_q.size()) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= stim_q[send_idx].data;
          s_axis_tlast <= stim_q[send_idx].last;
          if (!quiet_tail() && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 9);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result receiver, with one long hold-off to back the block up
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_result(res_t'({m_axis_tdata, m_axis_tuser}));
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!pressed && send_idx >= PRESS_AT) begin
        pressed = 1'b1;
        hold_left = PRESS_LEN - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet_tail() && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 8);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    seen_prev = 1'b0;
    keep_ch = '0;
    keep_rate = '0;
    keep_short = '0;
    keep_long = '0;
    keep_flag = 1'b0;
    clear_capture();
    build_stimulus();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (send_idx < stim_q.size() || pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== vorbis_packet_classifier.f =====
hw/rtl/vpc_pkg.sv
hw/rtl/vpc_capture.sv
hw/rtl/vpc_decide.sv
hw/rtl/vorbis_packet_classifier.sv
test/tb_top.sv
